@@ rtl/core/gbi_pkg.sv @@
package gbi_pkg;

  localparam int unsigned GBI_GRID_SIZE = 64;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  localparam logic [1:0] REG_HALF_EXTENT = 2'd0;
  localparam logic [1:0] REG_INV_SPACING = 2'd1;
  localparam logic [1:0] REG_FILL_VALUE  = 2'd2;

  localparam logic [30:0] HALF_EXTENT_RST = 31'd65536;
  localparam logic [30:0] INV_SPACING_RST = 31'd2064384;

  // Q1.16 unit weight.
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_EVAL,
    KIND_FILL
  } gbi_kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_FILL
  } gbi_state_e;

  // Width of one queue entry for a given grid index width.
  function automatic int unsigned gbi_entry_w(int unsigned iw);
    return 68 + 4 * iw;
  endfunction

endpackage

@@ rtl/core/gbi_if.sv @@
interface gbi_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic        [5:0]  row;
  logic        [5:0]  col;
  logic signed [31:0] entry_value;
  logic signed [31:0] px;
  logic signed [31:0] py;

  modport source (output valid, op, row, col, entry_value, px, py, input ready);
  modport sink   (input valid, op, row, col, entry_value, px, py, output ready);
endinterface

interface gbi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               out_of_range;

  modport source (output valid, result_value, out_of_range, input ready);
  modport sink   (input valid, result_value, out_of_range, output ready);
endinterface

interface gbi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/grid_bilinear_interpolator_unit.sv @@
// Bilinear interpolator over a square grid of signed Q16.16 samples.
// Three channels, each a valid/ready interface: cfg_i writes the
// registers (0 half extent, 1 reciprocal spacing, 2 fill value), in_i
// carries one operation per transaction (write entry, evaluate point,
// fill grid) and out_o returns exactly one result transaction for each.
// The front end registers the range check and the two coordinate scalings,
// splits the grid indices and pushes the classified item into a two-entry
// queue. The back end owns the grid memory and the multiply-accumulate.
// A write, an unused operation code or an out-of-range point goes straight
// into the result register when the back end takes it from the queue; an
// in-range evaluation makes four reads through the single read port of the
// grid memory and then passes the multiply and accumulate stages; a fill
// walks all GRID_SIZE*GRID_SIZE (4096) entries at one per cycle. The back
// end takes a new item only once it is idle and the result register is
// empty, so it finishes each item before it takes the next.
// After reset the back end runs the same walk writing zero to every entry,
// while in_i takes at most the front and queue depth of transactions;
// configuration writes are taken at any time.
// When out_o stalls, the result waits in its register and the queue plus
// the front stage keep absorbing up to three more transactions.
module grid_bilinear_interpolator_unit
  import gbi_pkg::*;
#(
  parameter int unsigned GRID_SIZE = GBI_GRID_SIZE
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbi_cfg_if.sink   cfg_i,
  gbi_in_if.sink    in_i,
  gbi_out_if.source out_o
);

  localparam int unsigned IW = $clog2(GRID_SIZE);
  localparam int unsigned EW = gbi_entry_w(IW);

  logic [30:0] half_extent_q, inv_spacing_q;
  logic [31:0] fill_value_q;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0] push_entry, pop_entry;

  // Configuration registers; the write channel never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_extent_q <= HALF_EXTENT_RST;
      inv_spacing_q <= INV_SPACING_RST;
      fill_value_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_HALF_EXTENT: half_extent_q <= cfg_i.data[30:0];
        REG_INV_SPACING: inv_spacing_q <= cfg_i.data[30:0];
        REG_FILL_VALUE:  fill_value_q  <= cfg_i.data;
        default:         fill_value_q  <= fill_value_q;
      endcase
    end
  end

  gbi_front #(
    .GRID_SIZE(GRID_SIZE),
    .IW       (IW),
    .EW       (EW)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .op_i         (in_i.op),
    .row_i        (in_i.row),
    .col_i        (in_i.col),
    .entry_value_i(in_i.entry_value),
    .px_i         (in_i.px),
    .py_i         (in_i.py),
    .half_extent_i(half_extent_q),
    .inv_spacing_i(inv_spacing_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  gbi_queue #(
    .W    (EW),
    .DEPTH(2)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_entry),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_entry)
  );

  gbi_back #(
    .GRID_SIZE(GRID_SIZE),
    .IW       (IW),
    .EW       (EW)
  ) u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_entry_i   (pop_entry),
    .fill_value_i  (fill_value_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .result_value_o(out_o.result_value),
    .out_of_range_o(out_o.out_of_range)
  );

endmodule

@@ rtl/core/gbi_front.sv @@
module gbi_front
  import gbi_pkg::*;
#(
  parameter int unsigned GRID_SIZE = GBI_GRID_SIZE,
  parameter int unsigned IW        = $clog2(GRID_SIZE),
  parameter int unsigned EW        = gbi_entry_w(IW)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [1:0]  op_i,
  input  logic        [5:0]  row_i,
  input  logic        [5:0]  col_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic        [30:0] half_extent_i,
  input  logic        [30:0] inv_spacing_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output logic [EW-1:0]      push_entry_o
);

  typedef struct packed {
    gbi_kind_e         kind;
    logic              oor;
    logic              wen;
    logic [31:0]       value;
    logic [15:0]       fx;
    logic [15:0]       fy;
    logic [IW-1:0]     x0;
    logic [IW-1:0]     x1;
    logic [IW-1:0]     y0;
    logic [IW-1:0]     y1;
  } entry_t;

  localparam logic [IW-1:0] LAST = IW'(GRID_SIZE - 1);

  logic              s_valid_q;
  logic [1:0]        s_op_q;
  logic [IW-1:0]     s_row_q, s_col_q;
  logic              s_wen_q;
  logic [31:0]       s_value_q;
  logic              s_oor_q;
  logic [62:0]       s_tx_q, s_ty_q;

  logic signed [32:0] r_s, ux, uy;
  logic               oor_d, push;
  entry_t             ent;

  // Stage 0: range check and scaling of both coordinates.
  assign r_s   = $signed({2'b00, half_extent_i});
  assign ux    = 33'(px_i) + r_s;
  assign uy    = 33'(py_i) + r_s;
  assign oor_d = (33'(px_i) < -r_s) || (33'(px_i) > r_s) ||
                 (33'(py_i) < -r_s) || (33'(py_i) > r_s);

  assign push         = s_valid_q && push_ready_i;
  assign in_ready_o   = !s_valid_q || push_ready_i;
  assign push_valid_o = s_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s_op_q    <= op_i;
      s_row_q   <= IW'(row_i);
      s_col_q   <= IW'(col_i);
      s_wen_q   <= (32'(row_i) < 32'(GRID_SIZE)) && (32'(col_i) < 32'(GRID_SIZE));
      s_value_q <= entry_value_i;
      s_oor_q   <= oor_d;
      s_tx_q    <= 63'(ux[31:0] * inv_spacing_i);
      s_ty_q    <= 63'(uy[31:0] * inv_spacing_i);
    end
  end

  // Stage 1: index split with saturation, then classification.
  always_comb begin
    ent       = '0;
    ent.oor   = s_oor_q;
    ent.wen   = s_wen_q;
    ent.value = s_value_q;
    ent.fx    = s_tx_q[31:16];
    ent.fy    = s_ty_q[31:16];
    unique case (s_op_q)
      OP_WRITE: begin
        ent.kind = KIND_WRITE;
        ent.x0   = s_row_q;
        ent.y0   = s_col_q;
      end
      OP_EVAL: begin
        ent.kind = KIND_EVAL;
        if (s_tx_q[62:32] >= 31'(GRID_SIZE - 1)) begin
          ent.x0 = LAST;
          ent.x1 = LAST;
        end else begin
          ent.x0 = s_tx_q[32 +: IW];
          ent.x1 = s_tx_q[32 +: IW] + 1'b1;
        end
        if (s_ty_q[62:32] >= 31'(GRID_SIZE - 1)) begin
          ent.y0 = LAST;
          ent.y1 = LAST;
        end else begin
          ent.y0 = s_ty_q[32 +: IW];
          ent.y1 = s_ty_q[32 +: IW] + 1'b1;
        end
      end
      OP_FILL: ent.kind = KIND_FILL;
      default: ent.kind = KIND_NONE;
    endcase
  end

  assign push_entry_o = ent;

  `ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q && !push_ready_i |=> s_valid_q && $stable(s_tx_q) && $stable(s_op_q))
    else $error("front stage lost a stalled item");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_valid_q |-> in_ready_o)
    else $error("front refused an item while empty");
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !s_valid_q || $past(in_valid_i))
    else $error("front stage kept a pushed item");
  `endif

endmodule

@@ rtl/core/gbi_queue.sv @@
module gbi_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/gbi_back.sv @@
module gbi_back
  import gbi_pkg::*;
#(
  parameter int unsigned GRID_SIZE = GBI_GRID_SIZE,
  parameter int unsigned IW        = $clog2(GRID_SIZE),
  parameter int unsigned EW        = gbi_entry_w(IW)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  logic [EW-1:0]      pop_entry_i,
  input  logic [31:0]        fill_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic               out_of_range_o
);

  typedef struct packed {
    gbi_kind_e         kind;
    logic              oor;
    logic              wen;
    logic [31:0]       value;
    logic [15:0]       fx;
    logic [15:0]       fy;
    logic [IW-1:0]     x0;
    logic [IW-1:0]     x1;
    logic [IW-1:0]     y0;
    logic [IW-1:0]     y1;
  } entry_t;

  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned DEPTH = 1 << AW;

  logic [31:0] mem_q [DEPTH];

  gbi_state_e   state_q, state_d;
  entry_t       in_ent, ent_q;
  logic [AW-1:0] cnt_q;
  logic [2:0]   step_q;
  logic [31:0]  sweep_val_q;
  logic         v1_q, v2_q;
  logic [32:0]  w_q, wt_d;
  logic [31:0]  rdata_q;
  logic signed [63:0] prod_q, acc_q;
  logic signed [65:0] prod_full;
  logic [63:0]  rounded;
  logic         out_valid_q, out_oor_q;
  logic [31:0]  out_val_q;

  logic         pop, mem_we, issue, load_out, out_oor_d;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]  mem_wdata, out_val_d;
  logic [16:0]  wx, wy;

  assign in_ent = pop_entry_i;
  assign pop    = pop_valid_i && pop_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (cnt_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (pop && in_ent.kind == KIND_FILL) begin
          state_d = ST_FILL;
        end else if (pop && in_ent.kind == KIND_EVAL && !in_ent.oor) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: if (step_q == 3'd6) state_d = ST_IDLE;
      ST_FILL: if (cnt_q == '1) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    pop_ready_o = (state_q == ST_IDLE) && !out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q;
    mem_wdata   = sweep_val_q;
    load_out    = 1'b0;
    out_val_d   = '0;
    out_oor_d   = 1'b0;
    issue       = (state_q == ST_EVAL) && !step_q[2];
    unique case (step_q[1:0])
      2'd0: begin mem_raddr = {ent_q.x0, ent_q.y0}; wx = WEIGHT_ONE - 17'(ent_q.fx); wy = WEIGHT_ONE - 17'(ent_q.fy); end
      2'd1: begin mem_raddr = {ent_q.x0, ent_q.y1}; wx = WEIGHT_ONE - 17'(ent_q.fx); wy = 17'(ent_q.fy); end
      2'd2: begin mem_raddr = {ent_q.x1, ent_q.y0}; wx = 17'(ent_q.fx); wy = WEIGHT_ONE - 17'(ent_q.fy); end
      default: begin mem_raddr = {ent_q.x1, ent_q.y1}; wx = 17'(ent_q.fx); wy = 17'(ent_q.fy); end
    endcase
    wt_d = 33'(wx * wy);
    unique case (state_q)
      ST_CLEAR, ST_FILL: begin
        mem_we = 1'b1;
        if (state_q == ST_FILL && cnt_q == '1) begin
          load_out = 1'b1;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          unique case (in_ent.kind)
            KIND_WRITE: begin
              mem_we    = in_ent.wen;
              mem_waddr = {in_ent.x0, in_ent.y0};
              mem_wdata = in_ent.value;
              load_out  = 1'b1;
            end
            KIND_EVAL: begin
              load_out  = in_ent.oor;
              out_oor_d = in_ent.oor;
            end
            KIND_FILL: load_out = 1'b0;
            default:   load_out = 1'b1;
          endcase
        end
      end
      ST_EVAL: begin
        if (step_q == 3'd6) begin
          load_out  = 1'b1;
          out_val_d = rounded[63:32];
        end
      end
      default: load_out = 1'b0;
    endcase
  end

  // Rounding toward zero of the Q16.48 sum down to Q16.16.
  assign rounded   = acc_q + (acc_q[63] ? 64'h0000_0000_FFFF_FFFF : 64'd0);
  assign prod_full = $signed(rdata_q) * $signed({1'b0, w_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      step_q      <= '0;
      sweep_val_q <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (state_q == ST_CLEAR || state_q == ST_FILL) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      step_q <= (state_q == ST_EVAL) ? step_q + 1'b1 : 3'd0;
      if (pop && in_ent.kind == KIND_FILL) begin
        sweep_val_q <= fill_value_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ent_q <= in_ent;
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + prod_q;
    end
    w_q    <= wt_d;
    prod_q <= prod_full[63:0];
    if (load_out) begin
      out_val_q <= out_val_d;
      out_oor_q <= out_oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[mem_raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign out_of_range_o = out_oor_q;

  `ifndef SYNTHESIS
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q)
    else $error("result register overwritten");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> state_q == ST_IDLE)
    else $error("item taken while the back end was busy");
  a_eval_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |-> !mem_we)
    else $error("grid written during an evaluation");
  a_eval_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |-> step_q <= 3'd6)
    else $error("evaluation sequencer overran");
  `endif

endmodule

@@ tb/sv/grid_bilinear_interpolator_unit_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the grid bilinear interpolator. A driver and a
// monitor run as clocked always blocks around the valid/ready channels,
// while the main initial block loads operations into the driver's queue in
// phases and reprograms the registers between phases once the block has
// gone quiet. Every accepted operation is run through a local predictor of
// the grid and its arithmetic, and the monitor checks each result
// transaction against the oldest prediction.
module grid_bilinear_interpolator_unit_test;
  import gbi_pkg::*;

  // Operation code 3 is unused by the block, and register index 3 is
  // ignored by it. Both are sent anyway to check that they change nothing.
  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned NCELLS    = GBI_GRID_SIZE * GBI_GRID_SIZE;
  // A fill or the clearing walk after reset runs with no transaction;
  // the limit allows for that walk several times over.
  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned MAX_GAP    = 17;

  typedef struct {
    logic [1:0]         op;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] entry_value;
    logic signed [31:0] px;
    logic signed [31:0] py;
    bit                 drain_first;
  } grid_op_t;

  typedef struct {
    logic signed [31:0] value;
    logic               oor;
  } grid_result_t;

  logic clk_i;
  logic rst_ni;

  gbi_cfg_if cfg_if ();
  gbi_in_if  in_if ();
  gbi_out_if out_if ();

  grid_bilinear_interpolator_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Local copy of the block's state and registers.
  logic [31:0] grid_mem [NCELLS];
  logic [30:0] half_q;
  logic [30:0] inv_q;
  logic [31:0] fill_q;

  grid_op_t     op_queue[$];
  grid_result_t result_queue[$];
  grid_op_t     cur_op;

  bit          sending;
  bit          op_taken;
  bit          result_taken;
  bit          calm;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned n_writes, n_evals, n_oor, n_fills, n_results;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap();
    if (calm) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Splits one coordinate into the lower and upper grid index and the
  // Q0.16 fraction between them. Indices saturate at the last index.
  function automatic void split_coord(input longint p, output int unsigned lo,
                                      output int unsigned hi,
                                      output longint frac);
    longint unsigned u;
    longint unsigned t;
    longint unsigned ip;
    u  = longint'(p) + longint'({33'd0, half_q});
    t  = u * {33'd0, inv_q};
    ip = t >> 32;
    if (ip >= GBI_GRID_SIZE - 1) begin
      lo = GBI_GRID_SIZE - 1;
      hi = GBI_GRID_SIZE - 1;
    end else begin
      lo = int'(ip);
      hi = lo + 1;
    end
    frac = longint'(t[31:16]);
  endfunction

  function automatic longint sample_at(int unsigned r, int unsigned c);
    return longint'($signed(grid_mem[r * GBI_GRID_SIZE + c]));
  endfunction

  // Applies one accepted operation to the local grid and returns the
  // result that the block must produce for it.
  function automatic grid_result_t interpolate_op(grid_op_t it);
    grid_result_t    res;
    longint          x, y, r, fx, fy, wx0, wx1, wy0, wy1, acc;
    longint unsigned mag;
    int unsigned     x0, x1, y0, y1;
    res.value = '0;
    res.oor   = 1'b0;
    case (it.op)
      OP_WRITE: begin
        grid_mem[it.row * GBI_GRID_SIZE + it.col] = it.entry_value;
        n_writes++;
      end
      OP_FILL: begin
        foreach (grid_mem[k]) grid_mem[k] = fill_q;
        n_fills++;
      end
      OP_EVAL: begin
        n_evals++;
        x = longint'(it.px);
        y = longint'(it.py);
        r = longint'({33'd0, half_q});
        if (x < -r || x > r || y < -r || y > r) begin
          res.oor = 1'b1;
          n_oor++;
        end else begin
          split_coord(x, x0, x1, fx);
          split_coord(y, y0, y1, fy);
          wx0 = 65536 - fx;
          wx1 = fx;
          wy0 = 65536 - fy;
          wy1 = fy;
          acc = sample_at(x0, y0) * (wx0 * wy0) + sample_at(x0, y1) * (wx0 * wy1)
              + sample_at(x1, y0) * (wx1 * wy0) + sample_at(x1, y1) * (wx1 * wy1);
          // Drop the Q0.32 weight scale, rounding toward zero.
          if (acc < 0) begin
            mag = longint'(0) - acc;
            res.value = -$signed(mag[63:32]);
          end else begin
            res.value = acc[63:32];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Input side: the posedge block records transactions and predicts,
  // the negedge block drives the next operation after a random gap.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      result_queue.push_back(interpolate_op(cur_op));
      op_taken = 1'b1;
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending  = 1'b0;
      op_taken = 1'b0;
      send_gap = 0;
      in_if.valid <= 1'b0;
    end else begin
      if (op_taken) begin
        op_taken = 1'b0;
        sending  = 1'b0;
        send_gap = draw_gap();
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (op_queue.size() > 0 &&
                     (!op_queue[0].drain_first || result_queue.size() == 0)) begin
          cur_op  = op_queue.pop_front();
          sending = 1'b1;
          in_if.op          <= cur_op.op;
          in_if.row         <= cur_op.row;
          in_if.col         <= cur_op.col;
          in_if.entry_value <= cur_op.entry_value;
          in_if.px          <= cur_op.px;
          in_if.py          <= cur_op.py;
        end
      end
      in_if.valid <= sending;
    end
  end

  // Output side: compare every result transaction with the oldest
  // prediction, then stall ready for a random number of cycles.
  always @(posedge clk_i) begin
    grid_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      result_taken = 1'b1;
      n_results++;
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: value %h oor %b",
                   $realtime, out_if.result_value, out_if.out_of_range);
      end else begin
        want = result_queue.pop_front();
        if (out_if.result_value !== want.value || out_if.out_of_range !== want.oor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch: expected value %h oor %b, got value %h oor %b",
                     $realtime, want.value, want.oor, out_if.result_value,
                     out_if.out_of_range);
        end
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_taken = 1'b0;
      recv_gap     = 0;
      out_if.ready <= 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        recv_gap     = draw_gap();
      end
      if (recv_gap > 0) recv_gap--;
      out_if.ready <= (recv_gap == 0);
    end
  end

  // Watchdog on cycles in which no channel completes a transaction.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", result_queue.size());
        $display("grid_bilinear_interpolator_unit_test failed");
        $finish;
      end
    end
  end

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_HALF_EXTENT: half_q = data[30:0];
      REG_INV_SPACING: inv_q  = data[30:0];
      REG_FILL_VALUE:  fill_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (op_queue.size() > 0 || sending || result_queue.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic grid_op_t make_op(logic [1:0] op, int r, int c, logic [31:0] v,
                                       logic [31:0] x, logic [31:0] y);
    grid_op_t it;
    it.op = op;
    it.row = 6'(r);
    it.col = 6'(c);
    it.entry_value = v;
    it.px = x;
    it.py = y;
    it.drain_first = 1'b0;
    return it;
  endfunction

  // Coordinate mostly inside [-R, R], sometimes on the edge, just outside,
  // or anywhere in the 32-bit range.
  function automatic logic [31:0] pick_coord();
    longint r;
    int unsigned sel;
    r = longint'({33'd0, half_q});
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom();
    if (sel == 1) return r;
    if (sel == 2) return -r;
    if (sel == 3 && r < 32'h7fffffff) return r + 1;
    if (sel == 4) return -r - 1;
    return longint'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic load_random(int unsigned count);
    int unsigned sel;
    grid_op_t    it;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)
        it = make_op(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), pick_value(),
                     $urandom(), $urandom());
      else if (sel < 97)
        it = make_op(OP_EVAL, $urandom(), $urandom(), $urandom(), pick_coord(),
                     pick_coord());
      else if (sel < 98)
        it = make_op(OP_FILL, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      else
        it = make_op(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      op_queue.push_back(it);
    end
  endtask

  initial begin
    grid_op_t hold_op;
    foreach (grid_mem[k]) grid_mem[k] = '0;
    half_q = HALF_EXTENT_RST;
    inv_q  = INV_SPACING_RST;
    fill_q = '0;
    calm = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    n_writes = 0; n_evals = 0; n_oor = 0; n_fills = 0; n_results = 0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_HALF_EXTENT;
    cfg_if.data  = '0;
    in_if.valid = 1'b0;
    in_if.op = OP_WRITE;
    in_if.row = '0;
    in_if.col = '0;
    in_if.entry_value = '0;
    in_if.px = '0;
    in_if.py = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with reset registers: corner writes at the value
    // extremes, points on both edges of the square and just outside it,
    // the saturated last index, the unused opcode and a fill of zero.
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 0, 0));
    op_queue.push_back(make_op(OP_WRITE, 0, 0, 32'h7fff_ffff, 0, 0));
    op_queue.push_back(make_op(OP_WRITE, 63, 63, 32'h8000_0000, 0, 0));
    op_queue.push_back(make_op(OP_WRITE, 0, 63, 32'hffff_ffff, 0, 0));
    op_queue.push_back(make_op(OP_WRITE, 63, 0, 32'h0001_0000, 0, 0));
    op_queue.push_back(make_op(OP_WRITE, 1, 1, 32'h0003_8000, 0, 0));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'hffff_0000, 32'hffff_0000));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'hffff_0000, 32'h0001_0000));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'h0001_0000, 32'hffff_0000));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'hffff_0800, 32'hffff_0123));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'h0000_fff0, 32'h0000_ffff));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'h0001_0001, 0));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 0, 32'hfffe_ffff));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff));
    op_queue.push_back(make_op(OP_NONE, 63, 63, 32'h1234_5678, 0, 0));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
    op_queue.push_back(make_op(OP_FILL, 0, 0, 0, 0, 0));
    op_queue.push_back(make_op(OP_EVAL, 0, 0, 0, 32'h0000_4000, 32'hffff_c000));
    wait_idle();

    // Each phase reprograms the registers, then runs random operations;
    // one operation per phase waits until all results have drained.
    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 2);
      case (phase)
        0: begin
          write_reg(REG_FILL_VALUE, 32'h8000_0000);
        end
        1: begin
          write_reg(REG_HALF_EXTENT, 32'd1);
          write_reg(REG_INV_SPACING, 32'd1);
          write_reg(REG_FILL_VALUE, 32'h7fff_ffff);
        end
        2: begin
          write_reg(REG_HALF_EXTENT, 32'h7fff_ffff);
          write_reg(REG_INV_SPACING, 32'h7fff_ffff);
          write_reg(REG_UNUSED, 32'hdead_beef);
        end
        3: begin
          // Half width just under 32768.0 with 63 intervals across the square.
          write_reg(REG_HALF_EXTENT, 32'h7fff_ffff);
          write_reg(REG_INV_SPACING, 32'd63);
          write_reg(REG_FILL_VALUE, $urandom());
        end
        4: begin
          write_reg(REG_HALF_EXTENT, 32'h0008_0000);
          write_reg(REG_INV_SPACING, 32'h0003_f000);
        end
        default: begin
          write_reg(REG_HALF_EXTENT, $urandom_range(1, 32'h7fff_ffff));
          write_reg(REG_INV_SPACING, $urandom_range(1, 32'h7fff_ffff));
          write_reg(REG_FILL_VALUE, $urandom());
        end
      endcase
      load_random(120);
      hold_op = make_op(OP_EVAL, 0, 0, 0, pick_coord(), pick_coord());
      hold_op.drain_first = 1'b1;
      op_queue.push_back(hold_op);
      load_random(120);
      wait_idle();
    end

    $display("covered %0d writes, %0d evaluations (%0d outside the square), %0d fills",
             n_writes, n_evals, n_oor, n_fills);
    $display("checked %0d results over 7 register settings, %0d mismatches",
             n_results, mismatches);
    if (mismatches == 0 && result_queue.size() == 0) begin
      $display("grid_bilinear_interpolator_unit_test passed");
    end else begin
      $display("grid_bilinear_interpolator_unit_test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/gbi_pkg.sv
rtl/core/gbi_if.sv
rtl/core/gbi_front.sv
rtl/core/gbi_queue.sv
rtl/core/gbi_back.sv
rtl/core/grid_bilinear_interpolator_unit.sv
tb/sv/grid_bilinear_interpolator_unit_test.sv
